>>> design/twf_pkg.sv
// Shared constants and controller/datapath handshake types for the training window finder.
package twf_pkg;

  localparam int unsigned MaxTaps  = 32;
  localparam int unsigned MaskW    = 32;
  localparam int unsigned TapW     = 5;
  localparam int unsigned CntW     = 6;
  localparam int unsigned PosW     = 7;
  localparam logic [CntW-1:0] TapCountReset = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } twf_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } twf_cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_last;
    logic out_busy;
  } twf_sts_t;

endpackage

>>> design/twf_in_if.sv
// Input channel carrying one training pass mask per transaction.
interface twf_in_if;
  import twf_pkg::*;
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] pass_mask;

  modport source (output valid, output pass_mask, input ready);
  modport sink   (input valid, input pass_mask, output ready);
endinterface

>>> design/twf_cfg_if.sv
// Configuration write channel carrying the tap count register value.
interface twf_cfg_if;
  import twf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] num_taps;

  modport source (output valid, output num_taps, input ready);
  modport sink   (input valid, input num_taps, output ready);
endinterface

>>> design/twf_out_if.sv
// Result channel carrying the window found for one pass mask.
interface twf_out_if;
  import twf_pkg::*;
  logic            valid;
  logic            ready;
  logic            status;
  logic            window_valid;
  logic            window_wrapped;
  logic [TapW-1:0] first_tap;
  logic [TapW-1:0] last_tap;
  logic [CntW-1:0] window_width;
  logic [TapW-1:0] center_tap;

  modport source (output valid, output status, output window_valid, output window_wrapped,
                  output first_tap, output last_tap, output window_width,
                  output center_tap, input ready);
  modport sink   (input valid, input status, input window_valid, input window_wrapped,
                  input first_tap, input last_tap, input window_width,
                  input center_tap, output ready);
endinterface

>>> design/twf_ctrl.sv
// Sequencer that loads a mask, steps the tap scan and hands the result to the output register.
module twf_ctrl
  import twf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  twf_sts_t sts_i,
  output twf_cmd_t cmd_o
);

  twf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.skip) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A new mask is only taken while no scan is in flight.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == ST_IDLE) else $error("load outside idle");
  // After a load the scan state always follows.
  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SCAN) else $error("load not followed by scan");
  // Only one command at a time.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("overlapping commands");

endmodule

>>> design/twf_datapath.sv
// Tap scan datapath: mask register, run tracker, best window and result register.
module twf_datapath
  import twf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [MaskW-1:0] pass_mask_i,
  twf_cfg_if.sink          cfg_i,
  twf_out_if.source        out_o,
  input  twf_cmd_t         cmd_i,
  output twf_sts_t         sts_o
);

  logic [CntW-1:0]  cnt_q;
  logic [MaskW-1:0] mask_q, mask_d;
  logic [TapW-1:0]  tap_q, tap_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  run_len_q, run_len_d;
  logic [TapW-1:0]  run_first_q, run_first_d;
  logic             run_ok_q, run_ok_d;
  logic [TapW-1:0]  lead_tap_q, lead_tap_d;
  logic [CntW-1:0]  best_width_q, best_width_d;
  logic             status_q, status_d;
  logic             skip_q, skip_d;
  logic             out_valid_q;

  logic             cnt_bad;
  logic [MaskW-1:0] used;
  logic [MaskW-1:0] masked;
  logic [TapW-1:0]  last_idx;
  logic             pass_now;
  logic [PosW-1:0]  last_sum;
  logic [PosW-1:0]  ctr_sum;
  logic [PosW-1:0]  cnt_ext;
  logic [TapW-1:0]  last_res;
  logic [TapW-1:0]  ctr_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= TapCountReset;
    end else if (cfg_i.valid) begin
      cnt_q <= cfg_i.num_taps;
    end
  end

  assign cnt_bad  = (cnt_q == '0) || (CntW'(MaxTaps) < cnt_q);
  assign used     = MaskW'((33'd1 << cnt_q) - 33'd1);
  assign masked   = pass_mask_i & used;
  assign last_idx = TapW'(cnt_q - CntW'(1));
  assign pass_now = mask_q[tap_q];
  assign cnt_ext  = PosW'(cnt_q);

  always_comb begin
    mask_d       = mask_q;
    tap_d        = tap_q;
    pos_d        = pos_q;
    run_len_d    = run_len_q;
    run_first_d  = run_first_q;
    run_ok_d     = run_ok_q;
    lead_tap_d   = lead_tap_q;
    best_width_d = best_width_q;
    status_d     = status_q;
    skip_d       = skip_q;
    if (cmd_i.load) begin
      mask_d       = masked;
      tap_d        = '0;
      pos_d        = '0;
      run_len_d    = '0;
      run_ok_d     = 1'b0;
      lead_tap_d   = '0;
      best_width_d = '0;
      status_d     = cnt_bad;
      skip_d       = 1'b1;
      if (!cnt_bad) begin
        if (masked == used) begin
          best_width_d = cnt_q;
        end else if (masked != '0) begin
          skip_d = 1'b0;
        end
      end
    end else if (cmd_i.step) begin
      pos_d = pos_q + PosW'(1);
      tap_d = (CntW'(tap_q) + CntW'(1) == cnt_q) ? '0 : tap_q + TapW'(1);
      if (pass_now) begin
        if (run_len_q == '0) begin
          run_first_d = tap_q;
          run_len_d   = CntW'(1);
          // A run counts only if it starts in the first pass after a failing tap.
          run_ok_d    = (pos_q < cnt_ext) && ((pos_q != '0) || !mask_q[last_idx]);
        end else begin
          run_len_d = run_len_q + CntW'(1);
        end
      end else begin
        if (run_ok_q && (run_len_q > best_width_q)) begin
          lead_tap_d   = run_first_q;
          best_width_d = run_len_q;
        end
        run_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q       <= mask_d;
    tap_q        <= tap_d;
    pos_q        <= pos_d;
    run_len_q    <= run_len_d;
    run_first_q  <= run_first_d;
    run_ok_q     <= run_ok_d;
    lead_tap_q   <= lead_tap_d;
    best_width_q <= best_width_d;
    status_q     <= status_d;
    skip_q       <= skip_d;
  end

  assign sts_o.skip      = skip_q;
  assign sts_o.scan_last = (pos_q == PosW'({cnt_q, 1'b0} - 7'd1));
  assign sts_o.out_busy  = out_valid_q && !out_o.ready;

  // Last and center taps, both below twice the tap count, folded back once.
  always_comb begin
    last_sum = PosW'(lead_tap_q) + PosW'(best_width_q) - PosW'(1);
    ctr_sum  = PosW'(lead_tap_q) + PosW'(best_width_q >> 1);
    last_res = (last_sum >= cnt_ext) ? TapW'(last_sum - cnt_ext) : TapW'(last_sum);
    ctr_res  = (ctr_sum >= cnt_ext) ? TapW'(ctr_sum - cnt_ext) : TapW'(ctr_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_o.status         <= status_q;
      out_o.window_valid   <= (best_width_q != '0);
      out_o.window_wrapped <= (best_width_q != '0) && (lead_tap_q > last_res);
      out_o.first_tap      <= lead_tap_q;
      out_o.last_tap       <= (best_width_q != '0) ? last_res : '0;
      out_o.window_width   <= best_width_q;
      out_o.center_tap     <= (best_width_q != '0) ? ctr_res : '0;
    end
  end

  assign out_o.valid = out_valid_q;

  // The result register is never overwritten while a result is still held back.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_o.ready)) else $error("result overwritten");
  // Scanning never runs past two passes over the taps.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (pos_q < PosW'({cnt_q, 1'b0}))) else $error("scan overran");
  // The scanning tap stays among the used taps.
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (CntW'(tap_q) < cnt_q)) else $error("tap out of range");
  // The best window never exceeds the tap count.
  a_width_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && !status_q |-> best_width_q <= cnt_q) else $error("width too large");

endmodule

>>> design/training_window_finder.sv
// Top level of the training window finder: controller, datapath and channel wiring.
//
// Usage: a pass mask arrives on the in_i channel, one bit per delay tap, and a
// transaction on out_o returns the widest circular run of passing taps among the
// taps in use (status, valid and wrap flags, first, last, width, center).
// The tap count register is written through cfg_i, which is always ready; it is
// meant to change only while no mask is being worked on.
// Timing: the mask is taken, then the scan walks one tap per cycle for two passes
// over the taps, and then the result register is loaded, which waits while the
// receiver still holds back the previous result. An invalid tap count, or a mask
// in which none or all of the taps in use pass, skips the walk. The single shared
// run tracker in the datapath sets the rate: one mask at a time, the next one only
// accepted once the previous result has been loaded into the output register.
// Reset clears the controller to idle, drops the output valid and sets the tap
// count to 32. When the receiver stalls, the finished result stays in the output
// register; the next mask can be taken and scanned meanwhile, and its result waits
// until the held one is taken.
module training_window_finder
  import twf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  twf_cfg_if.sink   cfg_i,
  twf_in_if.sink    in_i,
  twf_out_if.source out_o
);

  twf_cmd_t cmd;
  twf_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  // Sequencing of load, scan steps and result hand-off.
  twf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Tap scan, best window tracking and the output register.
  twf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pass_mask_i (in_i.pass_mask),
    .cfg_i       (cfg_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> tb/training_window_finder_tb.sv
// Self-checking testbench for the training window finder with directed and random pass masks.
`timescale 1ns / 1ps

module training_window_finder_tb;
  import twf_pkg::*;

  // Limit on the whole run, in clock cycles. The slowest correct run needs about
  // 1100 masks, each scanned over two passes of up to 32 taps, plus sender gaps and
  // receiver stalls, which stays well below this limit.
  localparam int unsigned CycleLimit   = 600000;
  // Cycles that one mask can keep the block busy, with some margin.
  localparam int unsigned ScanCycles   = 2 * MaxTaps + 8;
  localparam int unsigned RandomMasks  = 1030;
  localparam int unsigned MasksPerSet  = 40;
  localparam int unsigned MaxReports   = 10;

  // One result transaction as the checker sees it.
  typedef struct packed {
    logic            status;
    logic            window_valid;
    logic            window_wrapped;
    logic [TapW-1:0] first_tap;
    logic [TapW-1:0] last_tap;
    logic [CntW-1:0] window_width;
    logic [TapW-1:0] center_tap;
  } window_t;

  logic clk;
  logic rst_n;

  twf_cfg_if cfg_bus ();
  twf_in_if  mask_bus ();
  twf_out_if win_bus ();

  training_window_finder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (mask_bus),
    .out_o  (win_bus)
  );

  // Windows still owed by the block, oldest first.
  window_t         expected_windows[$];
  // Tap count the block holds, tracked from the configuration transactions.
  logic [CntW-1:0] taps_seen      = TapCountReset;
  int unsigned     mismatches     = 0;
  int unsigned     cycle_count    = 0;
  // Chance, in percent, that the sender or the receiver idles in a given cycle.
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_idle_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the widest circular run of passing taps for one mask. Runs are only
  // started at a tap whose circular predecessor fails, so a run that wraps past the
  // last tap is counted once, from its true start. A strictly wider run replaces the
  // best so far, which keeps the earliest start among runs of equal width.
  function automatic window_t find_window(input logic [CntW-1:0] taps,
                                          input logic [MaskW-1:0] mask);
    window_t     w;
    int          n;
    logic [63:0] used;
    logic [63:0] live;
    int          cand;
    int          prev;
    int          tap;
    int          run_len;
    int          pick_first;
    int          pick_last;
    int          best_len;
    w          = '0;
    n          = int'(taps);
    pick_first = 0;
    pick_last  = 0;
    best_len   = 0;
    if (n == 0 || n > int'(MaxTaps)) begin
      w.status = 1'b1;
      return w;
    end
    used = (64'd1 << n) - 64'd1;
    live = {32'd0, mask} & used;
    if (live == used) begin
      // Every tap in use passes: one window over all of them, never wrapped.
      pick_last = n - 1;
      best_len  = n;
    end else if (live != 64'd0) begin
      for (cand = 0; cand < n; cand++) begin
        prev = (cand == 0) ? n - 1 : cand - 1;
        if (live[cand] && !live[prev]) begin
          run_len = 0;
          tap     = cand;
          do begin
            run_len++;
            tap = (tap + 1 == n) ? 0 : tap + 1;
          end while (run_len < n && live[tap]);
          if (run_len > best_len) begin
            pick_first = cand;
            pick_last  = (tap == 0) ? n - 1 : tap - 1;
            best_len   = run_len;
          end
        end
      end
    end
    if (best_len != 0) begin
      w.window_valid   = 1'b1;
      w.window_wrapped = (pick_first > pick_last);
      w.first_tap      = TapW'(pick_first);
      w.last_tap       = TapW'(pick_last);
      w.window_width   = CntW'(best_len);
      w.center_tap     = TapW'((pick_first + best_len / 2) % n);
    end
    return w;
  endfunction

  // Mostly masks built from a few passing runs of random length and place, as a
  // real sweep would give them, with the rest random noise, all-pass or all-fail
  // patterns and garbage above the taps in use.
  function automatic logic [MaskW-1:0] random_mask(input logic [CntW-1:0] taps);
    logic [MaskW-1:0] m;
    logic [MaskW-1:0] used;
    int               n;
    int               runs;
    int               start;
    int               len;
    n    = (taps == 0 || taps > MaxTaps) ? int'(MaxTaps) : int'(taps);
    used = (n == 32) ? '1 : MaskW'((64'd1 << n) - 64'd1);
    case ($urandom_range(9))
      0: m = $urandom;
      1: m = $urandom_range(1) ? used : '0;
      default: begin
        m    = '0;
        runs = $urandom_range(1, 4);
        for (int r = 0; r < runs; r++) begin
          start = $urandom_range(n - 1);
          len   = $urandom_range(1, n);
          for (int k = 0; k < len; k++) begin
            m[(start + k) % n] = 1'b1;
          end
        end
        // An occasional stray pass or failure inside the taps in use.
        if ($urandom_range(3) == 0) begin
          m[$urandom_range(n - 1)] ^= 1'b1;
        end
      end
    endcase
    // Bits above the taps in use must not change the window.
    if ($urandom_range(1)) begin
      m = (m & used) | ($urandom & ~used);
    end
    return m;
  endfunction

  // Reset is asserted once and released on a rising edge.
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The receiver drops ready at random, at the rate of the current phase.
  initial begin
    win_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      win_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted mask owes one window, predicted with the tap count in force at
  // that time. Tap count writes only happen while no mask is in flight.
  always @(posedge clk) begin
    if (mask_bus.valid && mask_bus.ready) begin
      expected_windows.push_back(find_window(taps_seen, mask_bus.pass_mask));
    end
    if (cfg_bus.valid && cfg_bus.ready) begin
      taps_seen <= cfg_bus.num_taps;
    end
  end

  // Compares each window transaction with the oldest prediction.
  always @(posedge clk) begin
    window_t got;
    window_t want;
    if (win_bus.valid && win_bus.ready) begin
      got = '{win_bus.status, win_bus.window_valid, win_bus.window_wrapped,
              win_bus.first_tap, win_bus.last_tap, win_bus.window_width,
              win_bus.center_tap};
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected window transaction: sts %0d vld %0d wrap %0d first %0d last %0d",
                   got.status, got.window_valid, got.window_wrapped, got.first_tap,
                   got.last_tap);
        end
      end else begin
        want = expected_windows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("window mismatch at cycle %0d:", cycle_count);
            $display("  expected sts %0d vld %0d wrap %0d first %0d last %0d width %0d ctr %0d",
                     want.status, want.window_valid, want.window_wrapped, want.first_tap,
                     want.last_tap, want.window_width, want.center_tap);
            $display("  actual   sts %0d vld %0d wrap %0d first %0d last %0d width %0d ctr %0d",
                     got.status, got.window_valid, got.window_wrapped, got.first_tap,
                     got.last_tap, got.window_width, got.center_tap);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one mask, after a random number of idle cycles, and returns once the
  // block has taken it. Valid stays high on return so that a following mask can be
  // offered without dropping it.
  task automatic send_mask(input logic [MaskW-1:0] mask);
    while ($urandom_range(99) < send_idle_pct) begin
      mask_bus.valid <= 1'b0;
      @(posedge clk);
    end
    mask_bus.valid     <= 1'b1;
    mask_bus.pass_mask <= mask;
    @(posedge clk);
    while (!mask_bus.ready) @(posedge clk);
  endtask

  // Stops offering masks and waits until every predicted window has come back,
  // then lets the block settle for the given number of cycles.
  task automatic wait_idle(input int unsigned settle);
    mask_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes the tap count; only called while the block is idle.
  task automatic write_num_taps(input logic [CntW-1:0] taps);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.num_taps <= taps;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // With the tap count left at its reset value of 32: the empty and full masks,
  // single taps at both ends, a window wrapping past the last tap, alternating
  // taps, and two runs of equal width where the earlier one must win.
  task automatic test_reset_num_taps();
    logic [MaskW-1:0] masks[10];
    masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
              32'hC000_0003, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0000,
              32'hFFFF_FFFE, 32'h7FFF_FFFF};
    foreach (masks[i]) send_mask(masks[i]);
    wait_idle(4);
  endtask

  // Edge tap counts: the smallest, two, just below and at the maximum, and the
  // invalid zero, just above the maximum and all ones. Masks also carry passing
  // bits above the taps in use, which must be ignored.
  task automatic test_num_taps_edges();
    write_num_taps(CntW'(1));
    send_mask(32'h0000_0001);
    send_mask(32'hFFFF_FFFE);
    wait_idle(4);
    write_num_taps(CntW'(2));
    send_mask(32'h0000_0002);
    send_mask(32'hFFFF_FFFF);
    wait_idle(4);
    write_num_taps(CntW'(5));
    send_mask(32'hFFFF_FFE0);
    send_mask(32'hFFFF_FFF9);
    wait_idle(4);
    write_num_taps(CntW'(31));
    send_mask(32'h8000_0001);
    send_mask(32'h4000_0001);
    wait_idle(4);
    write_num_taps(CntW'(MaxTaps));
    send_mask(32'h8000_0001);
    wait_idle(4);
    write_num_taps(CntW'(0));
    send_mask(32'hFFFF_FFFF);
    wait_idle(4);
    write_num_taps(CntW'(MaxTaps + 1));
    send_mask(32'h0000_00FF);
    wait_idle(4);
    write_num_taps('1);
    send_mask(32'h1234_5678);
    wait_idle(4);
  endtask

  // Random masks in sets; each set starts with a new tap count, mostly a valid
  // one and now and then zero or above the maximum.
  task automatic test_random_windows(input int unsigned masks_to_send);
    int unsigned     sent;
    logic [CntW-1:0] taps;
    sent = 0;
    while (sent < masks_to_send) begin
      case ($urandom_range(19))
        0:       taps = '0;
        1:       taps = CntW'($urandom_range(MaxTaps + 1, 63));
        2:       taps = CntW'(MaxTaps);
        3:       taps = CntW'(1);
        default: taps = CntW'($urandom_range(1, MaxTaps));
      endcase
      write_num_taps(taps);
      for (int k = 0; k < MasksPerSet && sent < masks_to_send; k++) begin
        send_mask(random_mask(taps));
        sent++;
      end
      wait_idle(4);
    end
  endtask

  initial begin
    cfg_bus.valid      = 1'b0;
    cfg_bus.num_taps   = '0;
    mask_bus.valid     = 1'b0;
    mask_bus.pass_mask = '0;
    @(posedge rst_n);
    @(posedge clk);

    // Phase one: the sender idles a third of the time, the receiver more than half.
    send_idle_pct = 33;
    recv_idle_pct = 56;
    test_reset_num_taps();
    test_num_taps_edges();
    test_random_windows(RandomMasks / 3);

    // Phase two: the other way round.
    send_idle_pct = 56;
    recv_idle_pct = 33;
    test_random_windows(RandomMasks / 3);

    // Phase three: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_windows(RandomMasks - 2 * (RandomMasks / 3));

    wait_idle(ScanCycles);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
